// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfd_pkg;

  localparam int FRAME_BYTES = 13;
  localparam int WIN_BYTES   = FRAME_BYTES + 1;
  localparam int CRC_FIRST   = 3;
  localparam int CRC_SPAN    = FRAME_BYTES - CRC_FIRST;
  localparam int FILL_W      = $clog2(WIN_BYTES + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] HEADER_RESET   = 8'hAA;
  localparam logic [7:0] RIGHT_ID_RESET = 8'h82;
  localparam logic [7:0] LEFT_ID_RESET  = 8'h84;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ID  = 2'd2;

  // frame kind codes
  localparam logic [1:0] KIND_RIGHT = 2'd0;
  localparam logic [1:0] KIND_LEFT  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  // window contents plus the CRC of its bytes 3..12, handed to the checker
  typedef struct packed {
    logic                            valid;
    logic                            full;
    logic [15:0]                     crc;
    logic [WIN_BYTES-1:0][7:0]       win;
  } sfd_cand_t;

  // one byte through the reflected CRC-16 register
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sfd_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfd_frame_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sfd_frame_if;
  logic               valid;
  logic               ready;
  logic [7:0]         seq_byte;
  logic [7:0]         msg_id;
  logic signed [31:0] rear_word;
  logic signed [31:0] front_word;
  logic [1:0]         frame_kind;

  modport source (output valid, output seq_byte, output msg_id, output rear_word,
                  output front_word, output frame_kind, input ready);
  modport sink   (input valid, input seq_byte, input msg_id, input rear_word,
                  input front_word, input frame_kind, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfd_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sfd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sfd_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfd_window (
  input  wire logic               clk,
  input  wire logic               rst,
  sfd_byte_if.sink                rx,
  input  wire logic               take,
  output sfd_pkg::sfd_cand_t      cand
);

  logic [sfd_pkg::WIN_BYTES-1:0][7:0]  win;
  logic [sfd_pkg::WIN_BYTES-1:0][7:0]  win_next;
  // lane j holds the CRC of the last j+1 bytes received
  logic [sfd_pkg::CRC_SPAN-1:0][15:0]  lane;
  logic [sfd_pkg::CRC_SPAN-1:0][15:0]  lane_next;
  logic [15:0]                         crc_chk;
  logic [sfd_pkg::FILL_W-1:0]          fill_count;
  logic                                pend;
  logic                                accept;

  assign rx.ready = !pend || take;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    win_next = {rx.rx_byte, win[sfd_pkg::WIN_BYTES-1:1]};
    lane_next[0] = sfd_pkg::crc_byte(sfd_pkg::CRC_INIT, rx.rx_byte);
    for (int j = 1; j < sfd_pkg::CRC_SPAN; j++) begin
      lane_next[j] = sfd_pkg::crc_byte(lane[j-1], rx.rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      pend       <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
        if (fill_count != sfd_pkg::FILL_FULL) begin
          fill_count <= fill_count + 1'b1;
        end
      end else if (take) begin
        pend <= 1'b0;
      end
    end
  end

  // the 10 bytes before the new one are window bytes 3..12 after the shift
  always_ff @(posedge clk) begin
    if (accept) begin
      win     <= win_next;
      lane    <= lane_next;
      crc_chk <= lane[sfd_pkg::CRC_SPAN-1];
    end
  end

  assign cand.valid = pend;
  assign cand.full  = (fill_count == sfd_pkg::FILL_FULL);
  assign cand.crc   = crc_chk;
  assign cand.win   = win;

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= sfd_pkg::FILL_FULL)
    else $error("fill count past window size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (accept && pend) |-> take)
    else $error("candidate overwritten before the checker took it");

endmodule
`default_nettype wire

// ===== rtl/sfd_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfd_check (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sfd_pkg::sfd_cand_t cand,
  input  wire logic [7:0]         header_byte,
  input  wire logic [7:0]         right_speed_id,
  input  wire logic [7:0]         left_speed_id,
  output logic                    take,
  sfd_frame_if.source             res
);

  logic       match;
  logic [1:0] kind;

  assign take = cand.valid && (!res.valid || res.ready);

  assign match = cand.full
              && (cand.win[0] == header_byte)
              && (cand.win[sfd_pkg::FRAME_BYTES] == header_byte)
              && (cand.win[1] == cand.crc[7:0])
              && (cand.win[2] == cand.crc[15:8]);

  always_comb begin
    priority if (cand.win[4] == right_speed_id) begin
      kind = sfd_pkg::KIND_RIGHT;
    end else if (cand.win[4] == left_speed_id) begin
      kind = sfd_pkg::KIND_LEFT;
    end else begin
      kind = sfd_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= match;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && match) begin
      res.seq_byte   <= cand.win[3];
      res.msg_id     <= cand.win[4];
      res.rear_word  <= {cand.win[5], cand.win[6], cand.win[7], cand.win[8]};
      res.front_word <= {cand.win[9], cand.win[10], cand.win[11], cand.win[12]};
      res.frame_kind <= kind;
    end
  end

  a_no_result_unfilled: assert property (@(posedge clk) disable iff (rst)
    (take && !cand.full) |=> !res.valid)
    else $error("result before the window filled");

  a_right_kind: assert property (@(posedge clk) disable iff (rst)
    (take && match && cand.win[4] == right_speed_id) |=>
      (res.frame_kind == sfd_pkg::KIND_RIGHT))
    else $error("right speed id not reported as right");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.frame_kind != 2'd3))
    else $error("illegal frame kind");

endmodule
`default_nettype wire

// ===== rtl/serial_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Framed serial receiver with CRC-16 (reflected 0xA001, init 0xFFFF) check.
// rx: one received byte per transaction. res: one transaction per valid
// frame carrying seq_byte, msg_id, rear_word, front_word (big-endian signed)
// and frame_kind (right speeds, left speeds, other id).
// cfg: register writes (0 header_byte, 1 right_speed_id, 2 left_speed_id),
// always ready; other indexes are dropped. Write only while idle.
// A frame is the 13 bytes starting at a header byte and followed by another
// header byte, so its result appears after the following header arrives.
// Throughput: one byte per cycle while res is not stalled. Each byte lands in
// the window register when accepted, and the check stage then loads the result
// register; the CRC of bytes 3..12 comes from ten running CRC lanes, each
// advanced by one byte step per rx transaction.
// Reset: the config registers return to their defaults and the fill count clears; no
// frame is checked until 14 bytes have arrived.
// A stalled res holds its result; rx keeps accepting while the check stage
// can move, and backs up one stage later otherwise.
module serial_frame_deframer_crc16 (
  input  wire logic  clk,
  input  wire logic  rst,
  sfd_byte_if.sink   rx,
  sfd_frame_if.source res,
  sfd_cfg_if.sink    cfg
);

  logic [7:0]          header_byte;
  logic [7:0]          right_speed_id;
  logic [7:0]          left_speed_id;
  logic                take;
  sfd_pkg::sfd_cand_t  cand;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte    <= sfd_pkg::HEADER_RESET;
      right_speed_id <= sfd_pkg::RIGHT_ID_RESET;
      left_speed_id  <= sfd_pkg::LEFT_ID_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sfd_pkg::REG_HEADER:   header_byte    <= cfg.data;
        sfd_pkg::REG_RIGHT_ID: right_speed_id <= cfg.data;
        sfd_pkg::REG_LEFT_ID:  left_speed_id  <= cfg.data;
        default: ;
      endcase
    end
  end

  sfd_window u_window (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .cand (cand)
  );

  sfd_check u_check (
    .clk            (clk),
    .rst            (rst),
    .cand           (cand),
    .header_byte    (header_byte),
    .right_speed_id (right_speed_id),
    .left_speed_id  (left_speed_id),
    .take           (take),
    .res            (res)
  );

endmodule
`default_nettype wire

// ===== dv/tb_serial_frame_deframer_crc16.sv =====
`timescale 1ns / 1ps
module tb_serial_frame_deframer_crc16;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  // index 3 is not a register; writes to it must be dropped
  localparam logic [sfd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_BODY} flaw_t;

  typedef struct packed {
    logic [7:0]         seq;
    logic [7:0]         id;
    logic signed [31:0] rear;
    logic signed [31:0] front;
    logic [1:0]         kind;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_byte_if  rx_if ();
  sfd_frame_if res_if ();
  sfd_cfg_if   cfg_if ();

  logic                          src_valid = 1'b0;
  logic [7:0]                    src_byte = 8'h00;
  logic                          sink_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data = 8'h00;

  assign rx_if.valid   = src_valid;
  assign rx_if.rx_byte = src_byte;
  assign res_if.ready  = sink_ready;
  assign cfg_if.valid  = cfg_valid;
  assign cfg_if.index  = cfg_index;
  assign cfg_if.data   = cfg_data;

  serial_frame_deframer_crc16 u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] cfg_header = sfd_pkg::HEADER_RESET;
  logic [7:0] cfg_right_id = sfd_pkg::RIGHT_ID_RESET;
  logic [7:0] cfg_left_id = sfd_pkg::LEFT_ID_RESET;
  logic [7:0] win_model [sfd_pkg::WIN_BYTES];
  int         fill_seen = 0;

  logic [7:0] byte_feed [$];
  frame_t     frames_due [$];

  int   fails = 0;
  int   cyc = 0;
  logic quiet = 1'b0;
  logic hold_ready = 1'b0;
  bit   bulk_started = 1'b0;

  function automatic logic [15:0] modbus_crc16(input logic [7:0] span [sfd_pkg::CRC_SPAN]);
    logic [15:0] c;
    c = sfd_pkg::CRC_INIT;
    for (int i = 0; i < sfd_pkg::CRC_SPAN; i++) begin
      c = c ^ {8'h00, span[i]};
      for (int b = 0; b < 8; b++) begin
        if (c[0]) begin
          c = (c >> 1) ^ sfd_pkg::CRC_POLY;
        end else begin
          c = c >> 1;
        end
      end
    end
    return c;
  endfunction

  task automatic shift_in_byte(input logic [7:0] b);
    logic [7:0]  span [sfd_pkg::CRC_SPAN];
    logic [15:0] c;
    frame_t      f;
    for (int i = 0; i < sfd_pkg::WIN_BYTES - 1; i++) win_model[i] = win_model[i+1];
    win_model[sfd_pkg::WIN_BYTES-1] = b;
    if (fill_seen < sfd_pkg::WIN_BYTES) fill_seen++;
    if (fill_seen == sfd_pkg::WIN_BYTES && win_model[0] == cfg_header &&
        win_model[sfd_pkg::FRAME_BYTES] == cfg_header) begin
      for (int i = 0; i < sfd_pkg::CRC_SPAN; i++) span[i] = win_model[sfd_pkg::CRC_FIRST+i];
      c = modbus_crc16(span);
      if (win_model[1] == c[7:0] && win_model[2] == c[15:8]) begin
        f.seq   = win_model[3];
        f.id    = win_model[4];
        f.rear  = {win_model[5], win_model[6], win_model[7], win_model[8]};
        f.front = {win_model[9], win_model[10], win_model[11], win_model[12]};
        if (f.id == cfg_right_id) begin
          f.kind = sfd_pkg::KIND_RIGHT;
        end else if (f.id == cfg_left_id) begin
          f.kind = sfd_pkg::KIND_LEFT;
        end else begin
          f.kind = sfd_pkg::KIND_OTHER;
        end
        frames_due.push_back(f);
      end
    end
  endtask

  // frame bytes 0..12; the closing header comes from the next frame
  task automatic queue_frame(input logic [7:0] seq, input logic [7:0] id,
                             input logic [31:0] rear, input logic [31:0] front,
                             input flaw_t flaw);
    logic [7:0]  fb [sfd_pkg::FRAME_BYTES];
    logic [7:0]  span [sfd_pkg::CRC_SPAN];
    logic [15:0] c;
    int          k;
    fb[0] = cfg_header;
    fb[3] = seq;
    fb[4] = id;
    for (int i = 0; i < 4; i++) begin
      fb[5+i] = rear[31-8*i -: 8];
      fb[9+i] = front[31-8*i -: 8];
    end
    for (int i = 0; i < sfd_pkg::CRC_SPAN; i++) span[i] = fb[sfd_pkg::CRC_FIRST+i];
    c = modbus_crc16(span);
    if (flaw == FLAW_CRC) c = c ^ (16'd1 << $urandom_range(0, 15));
    fb[1] = c[7:0];
    fb[2] = c[15:8];
    if (flaw == FLAW_BODY) begin
      k = $urandom_range(sfd_pkg::CRC_FIRST, sfd_pkg::FRAME_BYTES - 1);
      fb[k] = fb[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    for (int i = 0; i < sfd_pkg::FRAME_BYTES; i++) byte_feed.push_back(fb[i]);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_frames(input int n);
    int          r;
    logic [7:0]  id;
    flaw_t       flaw;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        id = cfg_right_id;
      end else if (r < 7) begin
        id = cfg_left_id;
      end else begin
        id = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        flaw = FLAW_NONE;
      end else if (r < 93) begin
        flaw = FLAW_CRC;
      end else begin
        flaw = FLAW_BODY;
      end
      queue_frame(8'($urandom_range(0, 255)), id, pick_word(), pick_word(), flaw);
      // stray bytes break the closing header, sometimes with a false header
      if ($urandom_range(0, 99) < 12) begin
        r = $urandom_range(1, 4);
        for (int i = 0; i < r; i++) begin
          byte_feed.push_back(($urandom_range(0, 3) == 0) ? cfg_header
                                                           : 8'($urandom_range(0, 255)));
        end
      end
    end
    byte_feed.push_back(cfg_header);
  endtask

  task automatic write_reg(input logic [sfd_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    case (idx)
      sfd_pkg::REG_HEADER:   cfg_header = d;
      sfd_pkg::REG_RIGHT_ID: cfg_right_id = d;
      sfd_pkg::REG_LEFT_ID:  cfg_left_id = d;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (byte_feed.size() != 0 || src_valid || frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && rx_if.ready) shift_in_byte(src_byte);
      if (!src_valid || rx_if.ready) begin
        if (byte_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
          src_valid <= 1'b1;
          src_byte  <= byte_feed.pop_front();
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      sink_ready <= 1'b0;
    end else begin
      if (res_if.valid && sink_ready) begin
        if (frames_due.size() == 0) begin
          $error("unexpected frame transaction: seq_byte %0h msg_id %0h",
                 res_if.seq_byte, res_if.msg_id);
          fails++;
        end else begin
          want = frames_due.pop_front();
          if (res_if.seq_byte !== want.seq) begin
            $error("seq_byte: expected %0h, got %0h", want.seq, res_if.seq_byte);
            fails++;
          end
          if (res_if.msg_id !== want.id) begin
            $error("msg_id: expected %0h, got %0h", want.id, res_if.msg_id);
            fails++;
          end
          if (res_if.rear_word !== want.rear) begin
            $error("rear_word: expected %0d, got %0d", want.rear, res_if.rear_word);
            fails++;
          end
          if (res_if.front_word !== want.front) begin
            $error("front_word: expected %0d, got %0d", want.front, res_if.front_word);
            fails++;
          end
          if (res_if.frame_kind !== want.kind) begin
            $error("frame_kind: expected %0d, got %0d", want.kind, res_if.frame_kind);
            fails++;
          end
        end
      end
      sink_ready <= !hold_ready && (quiet || $urandom_range(0, 99) >= 24);
    end
  end

  // long result stall so the block backs up into rx, then a gap-free stretch
  initial begin
    wait (bulk_started);
    repeat (40) @(posedge clk);
    hold_ready <= 1'b1;
    repeat (300) @(posedge clk);
    hold_ready <= 1'b0;
    quiet <= 1'b1;
    repeat (200) @(posedge clk);
    quiet <= 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < sfd_pkg::WIN_BYTES; i++) win_model[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: partial window, extremes, every kind, bad CRC, broken header
    byte_feed.push_back(8'hAA);
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'hFF);
    queue_frame(8'h00, cfg_right_id, 32'h7FFF_FFFF, 32'h8000_0000, FLAW_NONE);
    queue_frame(8'hFF, cfg_left_id, 32'h0000_0000, 32'hFFFF_FFFF, FLAW_NONE);
    queue_frame(8'h5A, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, FLAW_NONE);
    queue_frame(8'h01, 8'hFF, $urandom, $urandom, FLAW_CRC);
    queue_frame(8'h02, cfg_right_id, $urandom, $urandom, FLAW_BODY);
    queue_frame(8'h03, cfg_left_id, $urandom, $urandom, FLAW_NONE);
    byte_feed.push_back(8'h55);
    queue_frame(8'h04, 8'hA5, $urandom, $urandom, FLAW_NONE);
    byte_feed.push_back(cfg_header);
    wait_idle();

    write_reg(sfd_pkg::REG_HEADER, 8'h00);
    write_reg(sfd_pkg::REG_RIGHT_ID, 8'hFF);
    write_reg(sfd_pkg::REG_LEFT_ID, 8'h00);
    write_reg(REG_NONE, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    queue_random_frames(8);
    wait_idle();

    // equal ids: a match must come out as right speeds
    write_reg(sfd_pkg::REG_HEADER, 8'hFF);
    write_reg(sfd_pkg::REG_RIGHT_ID, 8'h55);
    write_reg(sfd_pkg::REG_LEFT_ID, 8'h55);
    cfg_valid <= 1'b0;
    queue_random_frames(8);
    wait_idle();

    write_reg(sfd_pkg::REG_HEADER, sfd_pkg::HEADER_RESET);
    write_reg(sfd_pkg::REG_RIGHT_ID, sfd_pkg::RIGHT_ID_RESET);
    write_reg(sfd_pkg::REG_LEFT_ID, sfd_pkg::LEFT_ID_RESET);
    cfg_valid <= 1'b0;
    queue_random_frames(11);
    bulk_started = 1'b1;
    wait_idle();

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== serial_frame_deframer_crc16.f =====
rtl/sfd_pkg.sv
rtl/sfd_byte_if.sv
rtl/sfd_frame_if.sv
rtl/sfd_cfg_if.sv
rtl/sfd_window.sv
rtl/sfd_check.sv
rtl/serial_frame_deframer_crc16.sv
dv/tb_serial_frame_deframer_crc16.sv
